@@ design/tsrg_pkg.sv @@
// ----------------------------------------------------------------------------
// tsrg_pkg
// Shared types and constants of the trapezoid step ramp generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrg_pkg;

  localparam int STEP_BITS_DEF = 24;

  localparam int DELAY_W    = 16;
  localparam int RATE_W     = 16;
  localparam int MSTEPS_W   = 24;
  localparam int MOVE_W     = 24;
  localparam int POS_W      = 32;
  localparam int RC_W       = 32;
  localparam int RATE_SUM_W = RATE_W + 1;

  // 2 * interval + carried remainder, signed
  localparam int RNUM_W = RC_W + 2;

  // shared serial unit: 24 x 16 products and 40-bit dividends
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 16;
  localparam int NUM_W   = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_DATA_W = 56;

  localparam logic [DELAY_W-1:0]  FIRST_DELAY_RST  = 16'd10000;
  localparam logic [DELAY_W-1:0]  CRUISE_DELAY_RST = 16'd1000;
  localparam logic [MSTEPS_W-1:0] MAX_STEPS_RST    = 24'd100;
  localparam logic [RATE_W-1:0]   ACCEL_RST        = 16'd100;
  localparam logic [RATE_W-1:0]   DECEL_RST        = 16'd100;
  localparam logic [DELAY_W-1:0]  ONE_STEP_DELAY   = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_DELAY  = 3'd0,
    CFG_CRUISE_DELAY = 3'd1,
    CFG_MAX_STEPS    = 3'd2,
    CFG_ACCEL        = 3'd3,
    CFG_DECEL        = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_RUN   = 2'd2,
    PH_DECEL = 2'd3
  } phase_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_EVENT = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_LIM,
    ST_DIV_LIM,
    ST_MUL_CAP,
    ST_DIV_CAP,
    ST_RAMP_DIV,
    ST_FINISH
  } ctl_state_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

`default_nettype wire

@@ design/tsrg_muldiv.sv @@
// ----------------------------------------------------------------------------
// tsrg_muldiv
// Bit-serial unsigned unit: shift-add multiply (one multiplier bit per cycle)
// and restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module tsrg_muldiv
  import tsrg_pkg::*;
#(
  parameter int DVW = 26
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  alu_req_t       req_i,
  input  logic [NUM_W-1:0] opa_i,
  input  logic [DVW-1:0] opb_i,
  output logic           done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DVW-1:0] rem_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  alu_op_e            op_q, op_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [NUM_W-1:0]   acc_q, acc_d;
  logic [DVW-1:0]     rem_q, rem_d;
  logic [DVW-1:0]     divr_q, divr_d;
  logic [MUL_A_W-1:0] mcand_q, mcand_d;

  logic [DVW:0]       trial;
  logic [DVW:0]       diff;
  logic               fits;
  logic [CNT_W-1:0]   last_cnt;

  assign trial    = {rem_q, acc_q[NUM_W-1]};
  assign diff     = trial - {1'b0, divr_q};
  assign fits     = (trial >= {1'b0, divr_q});
  assign last_cnt = (op_q == OP_MUL) ? CNT_W'(MUL_B_W - 1) : CNT_W'(NUM_W - 1);

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    op_d    = op_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    divr_d  = divr_q;
    mcand_d = mcand_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      op_d    = req_i.op;
      cnt_d   = '0;
      acc_d   = (req_i.op == OP_MUL) ? '0 : opa_i;
      rem_d   = '0;
      divr_d  = opb_i;
      mcand_d = opa_i[MUL_A_W-1:0];
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        acc_d  = {acc_q[NUM_W-2:0], 1'b0}
               + (divr_q[MUL_B_W-1] ? NUM_W'(mcand_q) : '0);
        divr_d = {divr_q[DVW-2:0], 1'b0};
      end else begin
        rem_d = fits ? diff[DVW-1:0] : trial[DVW-1:0];
        acc_d = {acc_q[NUM_W-2:0], fits};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == last_cnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    divr_q  <= divr_d;
    mcand_q <= mcand_d;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ design/trapezoid_step_ramp_generator.sv @@
// ----------------------------------------------------------------------------
// trapezoid_step_ramp_generator
// Linear-ramp stepper interval generator with trapezoidal speed profile.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: write planning constants and rates while no move is active.
//   s_axis: tuser selects the transaction kind (0 start a move, 1 timer
//   compare event); tdata carries the signed step count for a start.
//   m_axis: one result per input transaction (interval, step flag, status).
// Sequencing: one transaction is processed at a time. A ramp event runs one
//   bit-serial divide before its result is registered. A start that plans a
//   ramp runs one multiply and one divide, plus a second multiply/divide pair
//   when the ramp is capped by max_steps. Other transactions do not use the
//   serial unit. The next input is taken once the result is registered.
//   Planning and ramp steps share the one multiply/divide unit.
// Reset: state clears to stop, position zero; registers take their defaults.
// Back-pressure: a finished result sits in the output register; the next
//   input transaction is taken at once, and its result waits until the
//   output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_step_ramp_generator
  import tsrg_pkg::*;
#(
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [MOVE_W-1:0]     s_axis_tdata,  // [23:0] move_steps
  input  logic                  s_axis_tuser,  // [0] req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] accepted, [16:1] compare_interval, [17] step_taken, [18] turn_ccw,
  // [19] moving, [51:20] position, [53:52] phase, [55:54] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = STEP_BITS + 1;
  localparam int DVW   = (STEP_BITS + 2 > RATE_SUM_W) ? STEP_BITS + 2 : RATE_SUM_W;

  // configuration
  logic [DELAY_W-1:0]  first_delay_q, cruise_delay_q;
  logic [MSTEPS_W-1:0] max_steps_q;
  logic [RATE_W-1:0]   accel_q, decel_q;

  // motion state
  phase_e              phase_q, phase_d;
  logic                dir_q, dir_d;
  logic                busy_q, busy_d;
  logic                half_q, half_d;
  logic [DELAY_W-1:0]  si_q, si_d;
  logic [IDX_W-1:0]    ridx_q, ridx_d;
  logic [RC_W-1:0]     rc_q, rc_d;
  logic [STEP_BITS-1:0] sd_q, sd_d;
  logic [STEP_BITS-1:0] dss_q, dss_d;
  logic [IDX_W-1:0]    dii_q, dii_d;
  logic [DELAY_W-1:0]  last_q, last_d;
  logic [POS_W-1:0]    pos_q, pos_d;

  // sequencing
  ctl_state_e          st_q, st_d;
  req_e                kind_q;
  logic [MOVE_W-1:0]   move_q;
  logic [MOVE_W-1:0]   lim_q, lim_d;
  logic                cap_q, cap_d;
  logic                commit;

  // output register
  logic                  mval_q;
  logic [OUT_DATA_W-1:0] mdata_q, mdata_d;

  // serial unit
  alu_req_t            alu_req;
  logic [NUM_W-1:0]    alu_a;
  logic [DVW-1:0]      alu_b;
  logic                alu_done;
  logic [NUM_W-1:0]    alu_quo;
  logic [DVW-1:0]      alu_rem;

  // decoded values
  logic [RATE_W-1:0]     a_eff, d_eff;
  logic [MSTEPS_W-1:0]   ms_eff;
  logic                  mv_neg;
  logic [MOVE_W-1:0]     s_mag;
  logic                  is_start;
  logic                  needs_plan;
  logic                  needs_ramp;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W+1:0]      den_s, den_abs;
  logic                  den_neg;
  logic [DVW-1:0]        den_mag;
  logic [RNUM_W-1:0]     num_s, num_mag;
  logic                  num_neg;
  logic [MOVE_W-1:0]     lim_raw, lim_nz;
  logic [63:0]           rem64, r64;
  logic [RC_W-1:0]       rc_new;
  logic [DELAY_W-1:0]    q_lo, q_sig, w;
  logic [NUM_W-1:0]      dvm, dvm1, dvm_neg;
  logic [MOVE_W-1:0]     ds;
  logic [STEP_BITS-1:0]  sd_inc;
  logic [POS_W-1:0]      pos_step;
  logic                  o_acc, o_taken;
  logic [DELAY_W-1:0]    o_ci;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q  <= FIRST_DELAY_RST;
      cruise_delay_q <= CRUISE_DELAY_RST;
      max_steps_q    <= MAX_STEPS_RST;
      accel_q        <= ACCEL_RST;
      decel_q        <= DECEL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIRST_DELAY:  first_delay_q  <= cfg_data_i[DELAY_W-1:0];
        CFG_CRUISE_DELAY: cruise_delay_q <= cfg_data_i[DELAY_W-1:0];
        CFG_MAX_STEPS:    max_steps_q    <= cfg_data_i[MSTEPS_W-1:0];
        CFG_ACCEL:        accel_q        <= cfg_data_i[RATE_W-1:0];
        CFG_DECEL:        decel_q        <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign a_eff  = (accel_q == '0) ? RATE_W'(1) : accel_q;
  assign d_eff  = (decel_q == '0) ? RATE_W'(1) : decel_q;
  assign ms_eff = (max_steps_q == '0) ? MSTEPS_W'(1) : max_steps_q;

  assign is_start = (kind_q == REQ_START);
  assign mv_neg   = move_q[MOVE_W-1];
  assign s_mag    = mv_neg ? (MOVE_W'(0) - move_q) : move_q;

  assign needs_plan = is_start && !busy_q && (s_mag > MOVE_W'(1));
  assign needs_ramp = !is_start && busy_q && half_q
                      && (phase_q == PH_ACCEL || phase_q == PH_DECEL);

  // ramp recurrence operands
  assign idx     = ridx_q + IDX_W'(1);
  assign den_s   = {idx, 2'b01};
  assign den_neg = idx[IDX_W-1];
  assign den_abs = den_neg ? (~den_s + (IDX_W+2)'(1)) : den_s;
  assign den_mag = DVW'(den_abs[IDX_W:0]);

  assign num_s   = {{(RNUM_W-DELAY_W-1){1'b0}}, si_q, 1'b0}
                 + {{(RNUM_W-RC_W){rc_q[RC_W-1]}}, rc_q};
  assign num_neg = num_s[RNUM_W-1];
  assign num_mag = num_neg ? (~num_s + RNUM_W'(1)) : num_s;

  assign rem64  = 64'(alu_rem);
  assign r64    = num_neg ? (~rem64 + 64'd1) : rem64;
  assign rc_new = r64[RC_W-1:0];
  assign q_lo   = alu_quo[DELAY_W-1:0];
  assign q_sig  = (num_neg ^ den_neg) ? (~q_lo + DELAY_W'(1)) : q_lo;
  assign w      = si_q - q_sig;

  // planning
  assign lim_raw = alu_quo[MOVE_W-1:0];
  assign lim_nz  = (lim_raw == '0) ? MOVE_W'(1) : lim_raw;
  assign dvm     = cap_q ? alu_quo : NUM_W'(s_mag - lim_q);
  assign dvm1    = (dvm == '0) ? NUM_W'(1) : dvm;
  assign dvm_neg = ~dvm1 + NUM_W'(1);
  assign ds      = (dvm1 <= NUM_W'(s_mag)) ? (s_mag - dvm1[MOVE_W-1:0]) : '0;

  assign sd_inc   = sd_q + STEP_BITS'(1);
  assign pos_step = dir_q ? (pos_q - POS_W'(1)) : (pos_q + POS_W'(1));

  // sequencer
  always_comb begin
    st_d          = st_q;
    lim_d         = lim_q;
    cap_d         = cap_q;
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_a         = NUM_W'(s_mag);
    alu_b         = DVW'(d_eff);
    commit        = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) st_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (needs_plan) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_MUL;
          alu_a         = NUM_W'(s_mag);
          alu_b         = DVW'(d_eff);
          cap_d         = 1'b0;
          st_d          = ST_MUL_LIM;
        end else if (needs_ramp) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_DIV;
          alu_a         = NUM_W'(num_mag);
          alu_b         = den_mag;
          st_d          = ST_RAMP_DIV;
        end else begin
          st_d = ST_FINISH;
        end
      end
      ST_MUL_LIM: begin
        if (alu_done) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_DIV;
          alu_a         = alu_quo;
          alu_b         = DVW'({1'b0, a_eff} + {1'b0, d_eff});
          st_d          = ST_DIV_LIM;
        end
      end
      ST_DIV_LIM: begin
        if (alu_done) begin
          lim_d = lim_nz;
          if (lim_nz <= ms_eff) begin
            st_d = ST_FINISH;
          end else begin
            cap_d         = 1'b1;
            alu_req.start = 1'b1;
            alu_req.op    = OP_MUL;
            alu_a         = NUM_W'(ms_eff);
            alu_b         = DVW'(a_eff);
            st_d          = ST_MUL_CAP;
          end
        end
      end
      ST_MUL_CAP: begin
        if (alu_done) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_DIV;
          alu_a         = alu_quo;
          alu_b         = DVW'(d_eff);
          st_d          = ST_DIV_CAP;
        end
      end
      ST_DIV_CAP, ST_RAMP_DIV: begin
        if (alu_done) st_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!mval_q || m_axis_tready) begin
          commit = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // transaction outcome
  always_comb begin
    phase_d = phase_q;
    dir_d   = dir_q;
    busy_d  = busy_q;
    half_d  = half_q;
    si_d    = si_q;
    ridx_d  = ridx_q;
    rc_d    = rc_q;
    sd_d    = sd_q;
    dss_d   = dss_q;
    dii_d   = dii_q;
    last_d  = last_q;
    pos_d   = pos_q;
    o_acc   = 1'b0;
    o_taken = 1'b0;
    o_ci    = '0;
    if (is_start) begin
      if (!busy_q) begin
        o_acc  = 1'b1;
        busy_d = 1'b1;
        dir_d  = mv_neg;
        if (s_mag == MOVE_W'(1)) begin
          ridx_d  = '1;
          phase_d = PH_DECEL;
          si_d    = ONE_STEP_DELAY;
        end else if (s_mag != '0) begin
          dii_d  = dvm_neg[IDX_W-1:0];
          dss_d  = STEP_BITS'(ds);
          ridx_d = '0;
          if (first_delay_q <= cruise_delay_q) begin
            si_d    = cruise_delay_q;
            phase_d = PH_RUN;
          end else begin
            si_d    = first_delay_q;
            phase_d = PH_ACCEL;
          end
        end
        o_ci = si_d;
      end
    end else if (busy_q) begin
      o_ci = si_q;
      if (!half_q) begin
        half_d = 1'b1;
      end else begin
        half_d = 1'b0;
        case (phase_q)
          PH_ACCEL: begin
            o_taken = 1'b1;
            sd_d    = sd_inc;
            pos_d   = pos_step;
            ridx_d  = idx;
            rc_d    = rc_new;
            si_d    = w;
            if (sd_inc >= dss_q) begin
              ridx_d  = dii_q;
              phase_d = PH_DECEL;
            end else if (w <= cruise_delay_q) begin
              last_d  = w;
              si_d    = cruise_delay_q;
              rc_d    = '0;
              phase_d = PH_RUN;
            end
          end
          PH_RUN: begin
            o_taken = 1'b1;
            sd_d    = sd_inc;
            pos_d   = pos_step;
            si_d    = cruise_delay_q;
            if (sd_inc >= dss_q) begin
              ridx_d  = dii_q;
              si_d    = last_q;
              phase_d = PH_DECEL;
            end
          end
          PH_DECEL: begin
            o_taken = 1'b1;
            sd_d    = sd_inc;
            pos_d   = pos_step;
            ridx_d  = idx;
            rc_d    = rc_new;
            si_d    = w;
            if (!idx[IDX_W-1]) phase_d = PH_STOP;
          end
          default: begin
            sd_d   = '0;
            rc_d   = '0;
            busy_d = 1'b0;
            si_d   = '0;
          end
        endcase
      end
    end
    mdata_d = {2'b00, phase_d, pos_d, busy_d, dir_d, o_taken, o_ci, o_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      mval_q  <= 1'b0;
      cap_q   <= 1'b0;
      phase_q <= PH_STOP;
      dir_q   <= 1'b0;
      busy_q  <= 1'b0;
      half_q  <= 1'b0;
      si_q    <= '0;
      ridx_q  <= '0;
      rc_q    <= '0;
      sd_q    <= '0;
      dss_q   <= '0;
      dii_q   <= '0;
      last_q  <= '0;
      pos_q   <= '0;
    end else begin
      st_q  <= st_d;
      cap_q <= cap_d;
      if (commit) begin
        mval_q  <= 1'b1;
        phase_q <= phase_d;
        dir_q   <= dir_d;
        busy_q  <= busy_d;
        half_q  <= half_d;
        si_q    <= si_d;
        ridx_q  <= ridx_d;
        rc_q    <= rc_d;
        sd_q    <= sd_d;
        dss_q   <= dss_d;
        dii_q   <= dii_d;
        last_q  <= last_d;
        pos_q   <= pos_d;
      end else if (m_axis_tready) begin
        mval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= req_e'(s_axis_tuser);
      move_q <= s_axis_tdata;
    end
    lim_q <= lim_d;
    if (commit) mdata_q <= mdata_d;
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;

  tsrg_muldiv #(
    .DVW (DVW)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (alu_a),
    .opb_i  (alu_b),
    .done_o (alu_done),
    .quo_o  (alu_quo),
    .rem_o  (alu_rem)
  );

endmodule

`default_nettype wire

@@ test/trapezoid_step_ramp_generator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_step_ramp_generator_checker
// Watches the register, request and result channels of the ramp generator,
// keeps its own copy of the ramp state and registers, computes the expected
// result of every accepted request and compares each result field by field.
// ----------------------------------------------------------------------------

module trapezoid_step_ramp_generator_checker
  import tsrg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [MOVE_W-1:0]     s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    result_count_o,
  output int                    pulse_count_o
);

  localparam int SB    = STEP_BITS_DEF;
  localparam int IDX_W = STEP_BITS_DEF + 1;

  typedef struct packed {
    logic [1:0]         phase;
    logic [POS_W-1:0]   position;
    logic               moving;
    logic               turn_ccw;
    logic               step_taken;
    logic [DELAY_W-1:0] interval;
    logic               accepted;
  } ramp_result_t;

  // register copies
  logic [DELAY_W-1:0]  first_delay, cruise_delay;
  logic [MSTEPS_W-1:0] max_steps;
  logic [RATE_W-1:0]   accel_rate, decel_rate;

  // ramp state
  phase_e             ph;
  logic               dir_ccw, busy, half;
  logic [DELAY_W-1:0] interval, last_ramp;
  logic [IDX_W-1:0]   ramp_idx, decel_idx;
  logic [RC_W-1:0]    rem;
  logic [SB-1:0]      steps_done, decel_at;
  logic [POS_W-1:0]   pos;

  ramp_result_t expected_results[$];

  function automatic void advance_position();
    steps_done = steps_done + SB'(1);
    pos = dir_ccw ? pos - POS_W'(1) : pos + POS_W'(1);
  endfunction

  // c' = c - (2c + r) / (4n + 1), remainder carried, truncating division
  function automatic longint next_interval();
    longint idx, den, num, iv, rc;
    ramp_idx = ramp_idx + IDX_W'(1);
    idx = longint'($signed(ramp_idx));
    iv = longint'(interval);
    rc = longint'($signed(rem));
    den = 4 * idx + 1;
    num = 2 * iv + rc;
    rc = num % den;
    rem = rc[RC_W-1:0];
    return iv - num / den;
  endfunction

  function automatic void plan_move(input logic [MOVE_W-1:0] count);
    longint sv, s, a, d, ms, lim, dv, ds;
    sv = longint'($signed(count));
    dir_ccw = (sv < 0);
    s = (sv < 0) ? -sv : sv;
    if (s == 1) begin
      ramp_idx = '1;
      ph = PH_DECEL;
      interval = ONE_STEP_DELAY;
    end else if (s != 0) begin
      a = longint'(accel_rate);
      d = longint'(decel_rate);
      ms = longint'(max_steps);
      if (a == 0) a = 1;
      if (d == 0) d = 1;
      if (ms == 0) ms = 1;
      lim = s * d / (a + d);
      if (lim == 0) lim = 1;
      if (lim <= ms) dv = lim - s;
      else dv = -(ms * a / d);
      if (dv == 0) dv = -1;
      ds = s + dv;
      if (ds < 0) ds = 0;
      decel_idx = dv[IDX_W-1:0];
      decel_at = ds[SB-1:0];
      if (first_delay <= cruise_delay) begin
        interval = cruise_delay;
        ph = PH_RUN;
      end else begin
        interval = first_delay;
        ph = PH_ACCEL;
      end
      ramp_idx = '0;
    end
    busy = 1'b1;
  endfunction

  function automatic logic take_step();
    longint nv;
    logic [DELAY_W-1:0] w;
    logic taken;
    nv = 0;
    taken = 1'b1;
    case (ph)
      PH_ACCEL: begin
        advance_position();
        nv = next_interval();
        w = nv[DELAY_W-1:0];
        if (steps_done >= decel_at) begin
          ramp_idx = decel_idx;
          ph = PH_DECEL;
        end else if (w <= cruise_delay) begin
          last_ramp = w;
          nv = longint'(cruise_delay);
          rem = '0;
          ph = PH_RUN;
        end
      end
      PH_RUN: begin
        advance_position();
        nv = longint'(cruise_delay);
        if (steps_done >= decel_at) begin
          ramp_idx = decel_idx;
          nv = longint'(last_ramp);
          ph = PH_DECEL;
        end
      end
      PH_DECEL: begin
        advance_position();
        nv = next_interval();
        if (!ramp_idx[IDX_W-1]) ph = PH_STOP;
      end
      default: begin
        steps_done = '0;
        rem = '0;
        busy = 1'b0;
        taken = 1'b0;
      end
    endcase
    interval = nv[DELAY_W-1:0];
    return taken;
  endfunction

  function automatic ramp_result_t compute_response(input req_e kind,
                                                    input logic [MOVE_W-1:0] count);
    ramp_result_t res;
    res = '0;
    if (kind == REQ_START) begin
      if (!busy) begin
        plan_move(count);
        res.accepted = 1'b1;
        res.interval = interval;
      end
    end else if (busy) begin
      res.interval = interval;
      if (!half) begin
        half = 1'b1;
      end else begin
        half = 1'b0;
        res.step_taken = take_step();
      end
    end
    res.turn_ccw = dir_ccw;
    res.moving = busy;
    res.position = pos;
    res.phase = ph;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    ramp_result_t want;
    if (!rst_ni) begin
      first_delay = FIRST_DELAY_RST;
      cruise_delay = CRUISE_DELAY_RST;
      max_steps = MAX_STEPS_RST;
      accel_rate = ACCEL_RST;
      decel_rate = DECEL_RST;
      ph = PH_STOP;
      dir_ccw = 1'b0;
      busy = 1'b0;
      half = 1'b0;
      interval = '0;
      last_ramp = '0;
      ramp_idx = '0;
      decel_idx = '0;
      rem = '0;
      steps_done = '0;
      decel_at = '0;
      pos = '0;
      expected_results.delete();
      fail_count_o = 0;
      result_count_o = 0;
      pulse_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FIRST_DELAY:  first_delay = cfg_data_i[DELAY_W-1:0];
          CFG_CRUISE_DELAY: cruise_delay = cfg_data_i[DELAY_W-1:0];
          CFG_MAX_STEPS:    max_steps = cfg_data_i[MSTEPS_W-1:0];
          CFG_ACCEL:        accel_rate = cfg_data_i[RATE_W-1:0];
          CFG_DECEL:        decel_rate = cfg_data_i[RATE_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_count_o++;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing outstanding: tdata 0x%0h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(m_axis_tdata[0]));
          check_field("compare_interval", 32'(want.interval), 32'(m_axis_tdata[16:1]));
          check_field("step_taken", 32'(want.step_taken), 32'(m_axis_tdata[17]));
          check_field("turn_ccw", 32'(want.turn_ccw), 32'(m_axis_tdata[18]));
          check_field("moving", 32'(want.moving), 32'(m_axis_tdata[19]));
          check_field("position", want.position, m_axis_tdata[51:20]);
          check_field("phase", 32'(want.phase), 32'(m_axis_tdata[53:52]));
          check_field("pad", '0, 32'(m_axis_tdata[55:54]));
          if (want.step_taken) pulse_count_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(compute_response(req_e'(s_axis_tuser), s_axis_tdata));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

@@ test/trapezoid_step_ramp_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_step_ramp_generator_tb
// Drives moves and timer compare events into the ramp generator under a
// series of register profiles (reset values, extremes, zeros, random), with
// random idle cycles on both streams; the checker predicts every result.
// ----------------------------------------------------------------------------

module trapezoid_step_ramp_generator_tb;
  import tsrg_pkg::*;

  localparam int RANDOM_ITEMS   = 360;
  localparam int PROFILE_ITEMS  = 60;
  localparam int IDLE_SPLIT     = 135;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [MOVE_W-1:0]     s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int fail_count, pending, result_count, pulse_count;
  int sent_items, cfg_writes, profiles;
  int tx_idle = 17;
  int rx_idle = 51;
  int quiet_cycles = 0;

  trapezoid_step_ramp_generator dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  trapezoid_step_ramp_generator_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count), .pulse_count_o(pulse_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("trapezoid_step_ramp_generator_tb: FAIL");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input req_e kind, input logic [MOVE_W-1:0] data);
    tx_idle = (sent_items < IDLE_SPLIT) ? 17 : (sent_items < 2 * IDLE_SPLIT) ? 51 : 0;
    rx_idle = (sent_items < IDLE_SPLIT) ? 51 : (sent_items < 2 * IDLE_SPLIT) ? 17 : 0;
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_events(input int n);
    logic [MOVE_W-1:0] junk;
    for (int i = 0; i < n; i++) begin
      junk = MOVE_W'($urandom);
      send_item(REQ_EVENT, junk);
    end
  endtask

  // a start followed by enough compare events to finish and go idle;
  // optionally a start with random data lands while the move is running
  task automatic run_move(input int unsigned mag, input bit ccw, input bit noisy);
    logic [MOVE_W-1:0] count, junk;
    int n_events, noise_at;
    count = mag[MOVE_W-1:0];
    if (ccw) count = -count;
    n_events = 2 * mag + 2 + $urandom_range(2, 0);
    noise_at = noisy ? int'($urandom_range(2 * mag + 1, 0)) : -1;
    send_item(REQ_START, count);
    for (int i = 0; i < n_events; i++) begin
      if (i == noise_at) begin
        junk = MOVE_W'($urandom);
        send_item(REQ_START, junk);
      end
      send_events(1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic load_regs(input logic [DELAY_W-1:0] first, input logic [DELAY_W-1:0] fastest,
                           input logic [MSTEPS_W-1:0] ramp_steps,
                           input logic [RATE_W-1:0] accel, input logic [RATE_W-1:0] decel);
    write_reg(CFG_FIRST_DELAY, CFG_DATA_W'(first));
    write_reg(CFG_CRUISE_DELAY, CFG_DATA_W'(fastest));
    write_reg(CFG_MAX_STEPS, ramp_steps);
    write_reg(CFG_ACCEL, CFG_DATA_W'(accel));
    write_reg(CFG_DECEL, CFG_DATA_W'(decel));
  endtask

  task automatic set_profile(input int p);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    case (p)
      1: load_regs(16'd3000, 16'd400, 24'd20, 16'd200, 16'd100);
      2: load_regs(16'hFFFF, 16'd1, 24'hFFFFFF, 16'hFFFF, 16'd1);
      3: begin
        write_reg(CFG_UNMAPPED, '1);
        load_regs('0, '0, '0, '0, '0);
      end
      4: load_regs(16'd500, 16'd500, 24'd5, 16'd1, 16'hFFFF);
      5, 6: load_regs(DELAY_W'($urandom_range(65535, 0)), DELAY_W'($urandom_range(4000, 0)),
                      MSTEPS_W'($urandom_range(64, 0)), RATE_W'($urandom_range(65535, 0)),
                      RATE_W'($urandom_range(65535, 0)));
      default: load_regs(FIRST_DELAY_RST, CRUISE_DELAY_RST, MAX_STEPS_RST, ACCEL_RST,
                         DECEL_RST);
    endcase
    cfg_valid_i <= 1'b0;
    profiles++;
  endtask

  initial begin
    int next_profile, random_start;
    int unsigned mag;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values: idle event, zero, one and two step moves, and starts of the largest counts while busy
    send_events(1);
    send_item(REQ_START, '0);
    send_item(REQ_START, 24'h800000);
    send_events(2);
    send_item(REQ_START, 24'd1);
    send_events(4);
    send_item(REQ_START, '1);
    send_events(4);
    send_item(REQ_START, 24'd2);
    send_item(REQ_START, 24'h7FFFFF);
    send_events(6);

    next_profile = 1;
    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      if (sent_items - random_start >= next_profile * PROFILE_ITEMS) begin
        set_profile(next_profile);
        next_profile++;
      end
      mag = ($urandom_range(99) < 85) ? $urandom_range(12, 0) : $urandom_range(48, 13);
      run_move(mag, $urandom_range(1, 0) == 1, $urandom_range(99) < 25);
    end
    set_profile(0);

    // largest step counts last: the move outlives the run
    send_item(REQ_START, 24'h800000);
    send_events(10);
    send_item(REQ_START, 24'h7FFFFF);
    send_events(2);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d transactions over %0d register profiles (%0d register writes);",
             sent_items, profiles + 1, cfg_writes);
    $display("checked %0d results covering %0d step pulses.", result_count, pulse_count);
    if (fail_count == 0 && pending == 0) begin
      $display("trapezoid_step_ramp_generator_tb: PASS");
    end else begin
      $display("trapezoid_step_ramp_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
